/* hw/rtl/rgbyuv_pkg.sv */
// Shared types, constants and arithmetic helpers for the RGB to YUV converter.
// No dependencies; imported by rgbyuv_csc, the converter top and the testbench.
`timescale 1ns / 1ps

package rgbyuv_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int SUM_W       = 28;
    localparam int STORE_W     = 27;
    localparam int MAX_WIDTH   = 2048;
    localparam int STORE_DEPTH = MAX_WIDTH / 2;
    localparam int SLOT_W      = $clog2(STORE_DEPTH);
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int LW_W        = 12;
    localparam int MODE_W      = 2;
    localparam int SH_W        = 5;

    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic signed [7:0]       chroma_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    // subsample modes
    localparam logic [MODE_W-1:0] MODE_444 = 2'd0;
    localparam logic [MODE_W-1:0] MODE_422 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_420 = 2'd2;

    // config register indexes
    localparam logic REG_LINE_WIDTH     = 1'b0;
    localparam logic REG_SUBSAMPLE_MODE = 1'b1;

    localparam logic [LW_W-1:0] LINE_WIDTH_RESET = LW_W'(640);
    localparam logic [LW_W-1:0] WIDTH_MIN        = LW_W'(2);
    localparam logic [LW_W-1:0] WIDTH_MAX        = LW_W'(MAX_WIDTH);

    // weights, round(c * 2^16)
    localparam sum_t K_Y_R = sum_t'(19595);
    localparam sum_t K_Y_G = sum_t'(38470);
    localparam sum_t K_Y_B = sum_t'(7471);
    localparam sum_t K_U_R = sum_t'(9642);
    localparam sum_t K_U_G = sum_t'(18931);
    localparam sum_t K_U_B = sum_t'(28574);
    localparam sum_t K_V_R = sum_t'(40305);
    localparam sum_t K_V_G = sum_t'(33750);
    localparam sum_t K_V_B = sum_t'(6554);

    // shifts for divide by 1, 2 or 4 samples
    localparam logic [SH_W-1:0] SH_1 = SH_W'(FRAC_BITS);
    localparam logic [SH_W-1:0] SH_2 = SH_W'(FRAC_BITS + 1);
    localparam logic [SH_W-1:0] SH_4 = SH_W'(FRAC_BITS + 2);

    // divide by 2^sh truncating toward zero, then saturate to 8 bits signed
    function automatic chroma_t div_sat(input sum_t sum, input logic [SH_W-1:0] sh);
        sum_t bias;
        sum_t q;
        bias = sum[SUM_W-1] ? ((sum_t'(1) <<< sh) - sum_t'(1)) : '0;
        q    = (sum + bias) >>> sh;
        if (q > sum_t'(127))
            div_sat = chroma_t'(127);
        else if (q < -sum_t'(128))
            div_sat = -chroma_t'(128);
        else
            div_sat = q[7:0];
    endfunction

endpackage

/* hw/rtl/rgbyuv_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rgbyuv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hw/rtl/rgbyuv_csc.sv */
// Color space matrix: one RGB pixel to clamped luma and unscaled U/V sums.
// Depends on rgbyuv_pkg.
`timescale 1ns / 1ps

module rgbyuv_csc import rgbyuv_pkg::*; (
    input  pixel_t     pix,
    output logic [7:0] luma,
    output sum_t       usum,
    output sum_t       vsum
);

    sum_t r;
    sum_t g;
    sum_t b;
    sum_t ysum;
    sum_t yint;

    assign r = sum_t'(pix.red);
    assign g = sum_t'(pix.green);
    assign b = sum_t'(pix.blue);

    assign ysum = K_Y_R * r + K_Y_G * g + K_Y_B * b;
    assign usum = K_U_B * b - K_U_R * r - K_U_G * g;
    assign vsum = K_V_R * r - K_V_G * g - K_V_B * b;

    assign yint = ysum >>> FRAC_BITS;
    assign luma = (yint > sum_t'(255)) ? 8'hFF : yint[7:0];

endmodule

/* hw/rtl/rgb_to_yuv_chroma_subsampler.sv */
// RGB to YUV converter with 4:4:4 / 4:2:2 / 4:2:0 chroma subsampling.
// Depends on rgbyuv_pkg, rgbyuv_csc and rgbyuv_ram (pair-sum line store).
// An accepted pixel passes the input register (stage 1), then the output
// register; stage 1 holds while that register is full. One pixel per cycle;
// input stalls only while both registers hold data and m_axis_tready is low.
// Reset sets config defaults, clears position, pair sums, handshake; not RAM.
`timescale 1ns / 1ps

module rgb_to_yuv_chroma_subsampler import rgbyuv_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [23:0]       s_axis_tdata,  // red, green, blue
    input  logic [0:0]        s_axis_tuser,  // frame_start
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [23:0]       m_axis_tdata,  // luma, chroma_u, chroma_v
    output logic [0:0]        m_axis_tuser,  // chroma_valid
    input  logic              cfg_wr_en,
    input  logic              cfg_addr,
    input  logic [LW_W-1:0]   cfg_wdata
);

    // configuration
    logic [LW_W-1:0]   line_width_reg;
    logic [MODE_W-1:0] mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RESET;
            mode_reg       <= MODE_444;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_LINE_WIDTH:     line_width_reg <= cfg_wdata;
                REG_SUBSAMPLE_MODE: mode_reg       <= cfg_wdata[MODE_W-1:0];
                default:            ;
            endcase
        end
    end

    logic [LW_W-1:0] eff_width;

    always_comb
    begin
        eff_width = {line_width_reg[LW_W-1:1], 1'b0};
        if (eff_width < WIDTH_MIN)
            eff_width = WIDTH_MIN;
        else if (eff_width > WIDTH_MAX)
            eff_width = WIDTH_MAX;
    end

    // handshake
    logic accept;
    logic s1_fire;
    logic out_free;
    logic s1_valid_reg;
    logic m_valid_reg;

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s1_fire       = s1_valid_reg && out_free;
    assign s_axis_tready = !s1_valid_reg || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // raster position
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic             odd_row_reg;
    logic             odd_row_next;
    logic [COL_W-1:0] col_cur;
    logic             row_cur;
    logic [LW_W-1:0]  col_inc;
    logic             wrap;

    assign col_cur      = s_axis_tuser[0] ? '0 : col_reg;
    assign row_cur      = s_axis_tuser[0] ? 1'b0 : odd_row_reg;
    assign col_inc      = LW_W'(col_cur) + LW_W'(1);
    assign wrap         = (col_inc >= eff_width);
    assign col_next     = wrap ? '0 : col_inc[COL_W-1:0];
    assign odd_row_next = row_cur ^ wrap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            odd_row_reg <= 1'b0;
        end
        else if (accept)
        begin
            col_reg     <= col_next;
            odd_row_reg <= odd_row_next;
        end
    end

    // line store of pair sums from even rows
    logic                      wr_en;
    logic [SLOT_W-1:0]         wr_addr;
    logic [2*STORE_W-1:0]      wr_data;
    logic [SLOT_W-1:0]         rd_addr;
    logic [2*STORE_W-1:0]      rd_data;

    assign rd_addr = col_cur[COL_W-1:1];

    rgbyuv_ram #(
        .WIDTH (2 * STORE_W),
        .DEPTH (STORE_DEPTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // stage 1 input register
    pixel_t               s1_pix_reg;
    logic                 s1_odd_col_reg;
    logic                 s1_odd_row_reg;
    logic [SLOT_W-1:0]    s1_slot_reg;
    logic                 s1_fwd_reg;
    logic [2*STORE_W-1:0] s1_fwd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_fire)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg      <= pixel_t'(s_axis_tdata);
            s1_odd_col_reg  <= col_cur[0];
            s1_odd_row_reg  <= row_cur;
            s1_slot_reg     <= rd_addr;
            // same-slot write at this edge: RAM returns old data, forward it
            s1_fwd_reg      <= wr_en && (wr_addr == rd_addr);
            s1_fwd_data_reg <= wr_data;
        end
    end

    // stage 1 datapath
    logic [7:0] luma;
    sum_t       usum;
    sum_t       vsum;

    rgbyuv_csc u_csc (
        .pix  (s1_pix_reg),
        .luma (luma),
        .usum (usum),
        .vsum (vsum)
    );

    sum_t                 pair_u_reg;
    sum_t                 pair_v_reg;
    sum_t                 pair_u;
    sum_t                 pair_v;
    logic [2*STORE_W-1:0] row_word;
    sum_t                 row_u;
    sum_t                 row_v;
    sum_t                 quad_u;
    sum_t                 quad_v;

    assign pair_u   = pair_u_reg + usum;
    assign pair_v   = pair_v_reg + vsum;
    assign row_word = s1_fwd_reg ? s1_fwd_data_reg : rd_data;
    assign row_u    = sum_t'(signed'(row_word[STORE_W-1:0]));
    assign row_v    = sum_t'(signed'(row_word[2*STORE_W-1:STORE_W]));
    assign quad_u   = row_u + pair_u;
    assign quad_v   = row_v + pair_v;

    assign wr_en   = s1_fire && s1_odd_col_reg && !s1_odd_row_reg;
    assign wr_addr = s1_slot_reg;
    assign wr_data = {pair_v[STORE_W-1:0], pair_u[STORE_W-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_u_reg <= '0;
            pair_v_reg <= '0;
        end
        else if (s1_fire && !s1_odd_col_reg)
        begin
            pair_u_reg <= usum;
            pair_v_reg <= vsum;
        end
    end

    logic    c_valid;
    chroma_t c_u;
    chroma_t c_v;

    always_comb
    begin
        case (mode_reg)
            MODE_422:
            begin
                c_valid = s1_odd_col_reg;
                c_u     = div_sat(pair_u, SH_2);
                c_v     = div_sat(pair_v, SH_2);
            end
            MODE_420:
            begin
                c_valid = s1_odd_col_reg && s1_odd_row_reg;
                c_u     = div_sat(quad_u, SH_4);
                c_v     = div_sat(quad_v, SH_4);
            end
            default:
            begin
                c_valid = 1'b1;
                c_u     = div_sat(usum, SH_1);
                c_v     = div_sat(vsum, SH_1);
            end
        endcase
        if (!c_valid)
        begin
            c_u = '0;
            c_v = '0;
        end
    end

    // output register
    logic [7:0] luma_reg;
    logic       c_valid_reg;
    chroma_t    c_u_reg;
    chroma_t    c_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (s1_fire)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            luma_reg    <= luma;
            c_valid_reg <= c_valid;
            c_u_reg     <= c_u;
            c_v_reg     <= c_v;
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = {c_v_reg, c_u_reg, luma_reg};
    assign m_axis_tuser[0] = c_valid_reg;

endmodule

/* verif/tb_rgb_to_yuv_chroma_subsampler.sv */
// Self-checking testbench for rgb_to_yuv_chroma_subsampler: directed table, then random
// raster frames in 4:4:4, 4:2:2 and 4:2:0 under varying source and sink idling.
// Depends on rgbyuv_pkg and block RTL; expected: typed directed rows, else a predictor.
`timescale 1ns / 1ps

module tb_rgb_to_yuv_chroma_subsampler;
    import rgbyuv_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 4;
    localparam int SEGMENTS     = 8;
    localparam int SEG_PIXELS   = 140;
    localparam int N_DIRECTED   = 38;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic ROW_PIX = 1'b0;
    localparam logic ROW_CFG = 1'b1;

    typedef struct packed {
        logic [7:0]        luma;
        logic              chroma_ok;
        logic signed [7:0] u;
        logic signed [7:0] v;
    } yuv_t;

    typedef struct packed {
        logic              kind;
        logic              addr;
        logic [LW_W-1:0]   wdata;
        logic              fs;
        logic [7:0]        r;
        logic [7:0]        g;
        logic [7:0]        b;
        logic              typed;
        yuv_t              res;
    } dir_row_t;

    function automatic longint fixed_weight(input longint k);
        return ((k << FRAC_BITS) + 64'd50000) / 64'd100000;
    endfunction

    localparam longint W_Y_R = fixed_weight(29900);
    localparam longint W_Y_G = fixed_weight(58700);
    localparam longint W_Y_B = fixed_weight(11400);
    localparam longint W_U_R = fixed_weight(14713);
    localparam longint W_U_G = fixed_weight(28886);
    localparam longint W_U_B = fixed_weight(43600);
    localparam longint W_V_R = fixed_weight(61500);
    localparam longint W_V_G = fixed_weight(51499);
    localparam longint W_V_B = fixed_weight(10001);
    localparam longint UNITY = longint'(1) << FRAC_BITS;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [23:0]       s_axis_tdata;
    logic [0:0]        s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [23:0]       m_axis_tdata;
    logic [0:0]        m_axis_tuser;
    logic              cfg_wr_en;
    logic              cfg_addr;
    logic [LW_W-1:0]   cfg_wdata;

    rgb_to_yuv_chroma_subsampler DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor state
    logic [LW_W-1:0]   reg_width = LINE_WIDTH_RESET;
    logic [MODE_W-1:0] reg_mode  = MODE_444;
    int unsigned       pos_col   = 0;
    logic              pos_odd_row = 1'b0;
    longint            pair_u    = 0;
    longint            pair_v    = 0;
    longint            line_u [STORE_DEPTH];
    longint            line_v [STORE_DEPTH];
    bit                line_written [STORE_DEPTH];

    yuv_t              expected_pixels [$];
    int                errors       = 0;
    int                cycle_count  = 0;
    int                tx_idle_pct  = 0;
    int                rx_stall_pct = 0;
    int                rx_hold_left = 0;

    // bytes at -37 / 127, -73 / -128, 111 / -25: U and V of saturated primaries
    dir_row_t directed_rows [N_DIRECTED] = '{
        '{ROW_PIX, 1'b0, 12'd0, 1'b1, 8'd0, 8'd0, 8'd0, 1'b1, '{8'd0, 1'b1, 8'sd0, 8'sd0}},
        '{ROW_PIX, 1'b0, 12'd0, 1'b0, 8'd255, 8'd255, 8'd255, 1'b1,
          '{8'd255, 1'b1, 8'sd0, 8'sd0}},
        '{ROW_PIX, 1'b0, 12'd0, 1'b0, 8'd255, 8'd0, 8'd0, 1'b1,
          '{8'd76, 1'b1, -8'sd37, 8'sd127}},
        '{ROW_PIX, 1'b0, 12'd0, 1'b0, 8'd0, 8'd255, 8'd0, 1'b1,
          '{8'd149, 1'b1, -8'sd73, 8'h80}},
        '{ROW_PIX, 1'b0, 12'd0, 1'b0, 8'd0, 8'd0, 8'd255, 1'b1,
          '{8'd29, 1'b1, 8'sd111, -8'sd25}},
        '{ROW_CFG, REG_LINE_WIDTH, 12'd4, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, '0},
        '{ROW_CFG, REG_SUBSAMPLE_MODE, {10'd0, MODE_422}, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, '0},
        '{ROW_PIX, 1'b0, 12'd0, 1'b1, 8'd255, 8'd0, 8'd0, 1'b1, '{8'd76, 1'b0, 8'sd0, 8'sd0}},
        '{ROW_PIX, 1'b0, 12'd0, 1'b0, 8'd0, 8'd0, 8'd255, 1'b0, '0},
        '{ROW_CFG, REG_LINE_WIDTH, 12'd2, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, '0},
        '{ROW_CFG, REG_SUBSAMPLE_MODE, {10'd0, MODE_420}, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, '0},
        '{ROW_PIX, 1'b0, 12'd0, 1'b1, 8'd255, 8'd255, 8'd0, 1'b0, '0},
        '{ROW_PIX, 1'b0, 12'd0, 1'b0, 8'd0, 8'd0, 8'd255, 1'b0, '0},
        '{ROW_PIX, 1'b0, 12'd0, 1'b0, 8'd255, 8'd0, 8'd0, 1'b1, '{8'd76, 1'b0, 8'sd0, 8'sd0}},
        '{ROW_PIX, 1'b0, 12'd0, 1'b0, 8'd0, 8'd255, 8'd0, 1'b0, '0},
        '{ROW_CFG, REG_LINE_WIDTH, 12'd3, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, '0},
        '{ROW_CFG, REG_SUBSAMPLE_MODE, {10'd0, MODE_UNUSED}, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, '0},
        '{ROW_PIX, 1'b0, 12'd0, 1'b1, 8'd0, 8'd255, 8'd255, 1'b0, '0},
        '{ROW_PIX, 1'b0, 12'd0, 1'b0, 8'd255, 8'd0, 8'd255, 1'b0, '0},
        '{ROW_CFG, REG_LINE_WIDTH, 12'd4095, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, '0},
        '{ROW_CFG, REG_SUBSAMPLE_MODE, {10'd0, MODE_420}, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, '0},
        '{ROW_PIX, 1'b0, 12'd0, 1'b1, 8'd255, 8'd255, 8'd255, 1'b1,
          '{8'd255, 1'b0, 8'sd0, 8'sd0}},
        '{ROW_PIX, 1'b0, 12'd0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b1, '{8'd0, 1'b0, 8'sd0, 8'sd0}},
        '{ROW_CFG, REG_LINE_WIDTH, 12'd8, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, '0},
        '{ROW_CFG, REG_SUBSAMPLE_MODE, {10'd0, MODE_422}, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, '0},
        '{ROW_PIX, 1'b0, 12'd0, 1'b1, 8'd200, 8'd17, 8'd90, 1'b0, '0},
        '{ROW_PIX, 1'b0, 12'd0, 1'b0, 8'd255, 8'd0, 8'd255, 1'b0, '0},
        '{ROW_PIX, 1'b0, 12'd0, 1'b0, 8'd0, 8'd255, 8'd0, 1'b0, '0},
        '{ROW_PIX, 1'b0, 12'd0, 1'b0, 8'd0, 8'd255, 8'd0, 1'b0, '0},
        '{ROW_PIX, 1'b0, 12'd0, 1'b0, 8'd255, 8'd0, 8'd0, 1'b0, '0},
        '{ROW_PIX, 1'b0, 12'd0, 1'b0, 8'd255, 8'd0, 8'd0, 1'b0, '0},
        '{ROW_CFG, REG_LINE_WIDTH, 12'd4, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, '0},
        '{ROW_CFG, REG_SUBSAMPLE_MODE, {10'd0, MODE_420}, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, '0},
        '{ROW_PIX, 1'b0, 12'd0, 1'b0, 8'd12, 8'd240, 8'd77, 1'b0, '0},
        '{ROW_PIX, 1'b0, 12'd0, 1'b0, 8'd255, 8'd0, 8'd0, 1'b0, '0},
        '{ROW_PIX, 1'b0, 12'd0, 1'b0, 8'd255, 8'd0, 8'd0, 1'b0, '0},
        '{ROW_CFG, REG_LINE_WIDTH, 12'd0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, '0},
        '{ROW_PIX, 1'b0, 12'd0, 1'b0, 8'd1, 8'd128, 8'd254, 1'b0, '0}
    };

    function automatic logic signed [7:0] chroma_of(input longint sum, input longint divisor);
        longint q;
        q = sum / divisor;
        if (q > 127)
            q = 127;
        if (q < -128)
            q = -128;
        return q[7:0];
    endfunction

    function automatic int unsigned line_pixels();
        int unsigned w;
        w = int'(reg_width) & ~1;
        if (w < 2)
            w = 2;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        return w;
    endfunction

    // advances the converter state by one pixel and returns its Y/U/V
    function automatic yuv_t predict_yuv(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b, input logic frame_start);
        longint ysum;
        longint usum;
        longint vsum;
        longint yv;
        int     slot;
        yuv_t   res;
        if (frame_start)
        begin
            pos_col     = 0;
            pos_odd_row = 1'b0;
        end
        ysum = W_Y_R * r + W_Y_G * g + W_Y_B * b;
        usum = W_U_B * b - W_U_R * r - W_U_G * g;
        vsum = W_V_R * r - W_V_G * g - W_V_B * b;
        yv = ysum >>> FRAC_BITS;
        if (yv > 255)
            yv = 255;
        slot = pos_col >> 1;
        if (slot >= STORE_DEPTH)
            slot = STORE_DEPTH - 1;
        if (!pos_col[0])
        begin
            pair_u = usum;
            pair_v = vsum;
        end
        res = '0;
        res.luma = yv[7:0];
        if (reg_mode == MODE_422)
        begin
            if (pos_col[0])
            begin
                res.chroma_ok = 1'b1;
                res.u = chroma_of(pair_u + usum, 2 * UNITY);
                res.v = chroma_of(pair_v + vsum, 2 * UNITY);
            end
        end
        else if (reg_mode == MODE_420)
        begin
            if (pos_col[0] && pos_odd_row)
            begin
                res.chroma_ok = 1'b1;
                res.u = chroma_of(line_u[slot] + pair_u + usum, 4 * UNITY);
                res.v = chroma_of(line_v[slot] + pair_v + vsum, 4 * UNITY);
            end
        end
        else
        begin
            res.chroma_ok = 1'b1;
            res.u = chroma_of(usum, UNITY);
            res.v = chroma_of(vsum, UNITY);
        end
        if (pos_col[0] && !pos_odd_row)
        begin
            line_u[slot]       = pair_u + usum;
            line_v[slot]       = pair_v + vsum;
            line_written[slot] = 1'b1;
        end
        pos_col++;
        if (pos_col >= line_pixels())
        begin
            pos_col     = 0;
            pos_odd_row = ~pos_odd_row;
        end
        return res;
    endfunction

    task automatic send_pixel(input logic [23:0] data, input logic frame_start);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= frame_start;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic issue_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                               input logic frame_start, input logic typed, input yuv_t res);
        logic fs;
        yuv_t pred;
        fs = frame_start;
        // an odd-row block whose upper pair was never stored: restart the frame instead
        if (reg_mode == MODE_420 && !fs && pos_col[0] && pos_odd_row &&
            !line_written[pos_col >> 1])
            fs = 1'b1;
        pred = predict_yuv(r, g, b, fs);
        expected_pixels.push_back(typed ? res : pred);
        send_pixel({b, g, r}, fs);
    endtask

    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic addr, input logic [LW_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        if (addr == REG_LINE_WIDTH)
            reg_width = value;
        else
            reg_mode = value[MODE_W-1:0];
    endtask

    function automatic logic [7:0] rand_channel();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [LW_W-1:0] pick_width();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 5))
                    0: return 12'd0;
                    1: return 12'd1;
                    2: return 12'd2047;
                    3: return 12'd4095;
                    4: return 12'd4094;
                    default: return WIDTH_MAX;
                endcase
            end
            1, 2: return LW_W'($urandom_range(1, 40));
            default: return LW_W'(2 * $urandom_range(1, 16));
        endcase
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode();
        int p;
        p = $urandom_range(0, 99);
        if (p < 15)
            return MODE_444;
        else if (p < 45)
            return MODE_422;
        else if (p < 90)
            return MODE_420;
        else
            return MODE_UNUSED;
    endfunction

    task automatic note_error();
        errors++;
    endtask

    always @(negedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_hold_left  <= rx_hold_left - 1;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin : check_results
        yuv_t want;
        yuv_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.luma      = m_axis_tdata[7:0];
            got.u         = m_axis_tdata[15:8];
            got.v         = m_axis_tdata[23:16];
            got.chroma_ok = m_axis_tuser[0];
            if (expected_pixels.size() == 0)
            begin
                note_error();
                if (errors <= 10)
                    $display("unexpected transaction: luma %0d cv %0d u %0d v %0d",
                             got.luma, got.chroma_ok, got.u, got.v);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (got !== want)
                begin
                    note_error();
                    if (errors <= 10)
                        $display("mismatch exp/act: luma %0d/%0d cv %0d/%0d u %0d/%0d v %0d/%0d",
                                 want.luma, got.luma, want.chroma_ok, got.chroma_ok,
                                 want.u, got.u, want.v, got.v);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_rgb_to_yuv_chroma_subsampler: done, errors");
            $finish;
        end
    end

    initial
    begin : stimulus
        dir_row_t row;
        int       seg;
        int       k;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = 1'b0;
        cfg_wdata     = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG)
            begin
                wait_all_results();
                write_reg(row.addr, row.wdata);
            end
            else
                issue_pixel(row.r, row.g, row.b, row.fs, row.typed, row.res);
        end

        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            wait_all_results();
            case (seg % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 77; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 77; end
                default: begin tx_idle_pct = 15; rx_stall_pct = 15; end
            endcase
            write_reg(REG_LINE_WIDTH, pick_width());
            write_reg(REG_SUBSAMPLE_MODE, {{(LW_W - MODE_W){1'b0}}, pick_mode()});
            for (k = 0; k < SEG_PIXELS; k++)
            begin
                // long sink backpressure while the source keeps streaming
                if (seg == 0 && k == 40)
                    rx_hold_left = 300;
                if (seg == 1 && k == 70)
                    wait_all_results();
                issue_pixel(rand_channel(), rand_channel(), rand_channel(),
                            (k == 0) || ($urandom_range(0, 59) == 0), 1'b0, '0);
            end
        end

        wait_all_results();
        repeat (8) @(negedge clk);
        if (errors == 0)
            $display("tb_rgb_to_yuv_chroma_subsampler: done, clean");
        else
            $display("tb_rgb_to_yuv_chroma_subsampler: done, errors");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/rgbyuv_pkg.sv
hw/rtl/rgbyuv_ram.sv
hw/rtl/rgbyuv_csc.sv
hw/rtl/rgb_to_yuv_chroma_subsampler.sv
verif/tb_rgb_to_yuv_chroma_subsampler.sv
